@@ design/dlls_pkg.sv @@
// Shared types and constants for the doubly linked list store.
package dlls_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int CMD_W        = 2;
   localparam int POS_W        = 7;
   localparam int VALUE_W      = 32;
   localparam int STATUS_W     = 3;
   localparam int COUNT_OUT_W  = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_BACK  = 2'd1,
      CMD_INSERT     = 2'd2,
      CMD_READ_OUT   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_RANGE    = 3'd1,
      ST_FULL     = 3'd2,
      ST_ELEMENT  = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef struct packed {
      logic data_we;
      logic next_we;
      logic rd_en;
   } mem_ctl_type;

endpackage

@@ design/dlls_node_mem.sv @@
// Node pool memories: element values and next links, one registered read port.
module dlls_node_mem #(
   parameter int  CAPACITY = dlls_pkg::CAPACITY_DEF,
   localparam int SLOT_W   = $clog2(CAPACITY)
) (
   input  logic                                clock,
   input  dlls_pkg::mem_ctl_type               ctl,
   input  logic [SLOT_W-1:0]                   data_addr,
   input  logic signed [dlls_pkg::VALUE_W-1:0] data_wdata,
   input  logic [SLOT_W-1:0]                   next_addr,
   input  logic [SLOT_W-1:0]                   next_wdata,
   input  logic [SLOT_W-1:0]                   rd_addr,
   output logic signed [dlls_pkg::VALUE_W-1:0] rd_data_ff,
   output logic [SLOT_W-1:0]                   rd_next_ff
);

   logic signed [dlls_pkg::VALUE_W-1:0] data_mem [CAPACITY];
   logic [SLOT_W-1:0]                   next_mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (ctl.data_we) begin
         data_mem[data_addr] <= data_wdata;
      end
      if (ctl.next_we) begin
         next_mem[next_addr] <= next_wdata;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= data_mem[rd_addr];
         rd_next_ff <= next_mem[rd_addr];
      end
   end

endmodule

@@ design/dlls_ctrl.sv @@
// Command sequencer: list walks, link updates, list registers and result register.
module dlls_ctrl #(
   parameter int  CAPACITY = dlls_pkg::CAPACITY_DEF,
   localparam int SLOT_W   = $clog2(CAPACITY),
   localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [dlls_pkg::CMD_W-1:0]              req_cmd,
   input  logic [dlls_pkg::POS_W-1:0]              req_position,
   input  logic signed [dlls_pkg::VALUE_W-1:0]     req_item_value,
   output logic                                    rsp_valid_ff,
   input  logic                                    rsp_tready,
   output logic [dlls_pkg::STATUS_W-1:0]           rsp_status_ff,
   output logic signed [dlls_pkg::VALUE_W-1:0]     rsp_value_ff,
   output logic                                    rsp_last_ff,
   output logic [dlls_pkg::COUNT_OUT_W-1:0]        rsp_count_ff,
   output dlls_pkg::mem_ctl_type                   ctl,
   output logic [SLOT_W-1:0]                       data_addr,
   output logic signed [dlls_pkg::VALUE_W-1:0]     data_wdata,
   output logic [SLOT_W-1:0]                       next_addr,
   output logic [SLOT_W-1:0]                       next_wdata,
   output logic [SLOT_W-1:0]                       rd_addr,
   input  logic signed [dlls_pkg::VALUE_W-1:0]     rd_data_ff,
   input  logic [SLOT_W-1:0]                       rd_next_ff
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_WALK   = 4'b0010,
      S_STITCH = 4'b0100,
      S_READ   = 4'b1000
   } state_type;

   state_type                           state_ff, state_in;
   logic [SLOT_W-1:0]                   head_ff, head_in;
   logic [SLOT_W-1:0]                   tail_ff, tail_in;
   logic [SLOT_W-1:0]                   cur_ff, cur_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [CNT_W-1:0]                    rem_ff, rem_in;
   logic signed [dlls_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                                rsp_valid_in;
   logic [dlls_pkg::STATUS_W-1:0]       rsp_status_in;
   logic signed [dlls_pkg::VALUE_W-1:0] rsp_value_in;
   logic                                rsp_last_in;
   logic [dlls_pkg::COUNT_OUT_W-1:0]    rsp_count_in;

   logic                                out_free;
   logic                                accept;
   logic                                full;
   logic                                range_bad;
   logic                                is_empty;
   logic [SLOT_W-1:0]                   new_slot;
   logic [CNT_W-1:0]                    count_inc;
   logic [dlls_pkg::POS_W-1:0]          count_pos;
   logic [dlls_pkg::POS_W-1:0]          pos_m1;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign is_empty   = (count_ff == '0);
   assign count_pos  = dlls_pkg::POS_W'(count_ff);
   assign range_bad  = (req_cmd == dlls_pkg::CMD_INSERT) && (req_position > count_pos);
   assign new_slot   = count_ff[SLOT_W-1:0];
   assign count_inc  = count_ff + CNT_W'(1);
   assign pos_m1     = req_position - dlls_pkg::POS_W'(1);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cur_in        = cur_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      value_in      = value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;
      ctl           = '0;
      data_addr     = new_slot;
      data_wdata    = req_item_value;
      next_addr     = new_slot;
      next_wdata    = head_ff;
      rd_addr       = head_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_value_in = '0;
               rsp_last_in  = 1'b1;
               rsp_count_in = dlls_pkg::COUNT_OUT_W'(count_ff);
               if (req_cmd == dlls_pkg::CMD_READ_OUT) begin
                  if (is_empty) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = dlls_pkg::ST_EMPTY;
                  end else begin
                     ctl.rd_en = 1'b1;
                     rem_in    = count_ff - CNT_W'(1);
                     state_in  = S_READ;
                  end
               end else if (range_bad) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = dlls_pkg::ST_RANGE;
               end else if (full) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = dlls_pkg::ST_FULL;
               end else if (req_cmd == dlls_pkg::CMD_PUSH_FRONT ||
                            (req_cmd == dlls_pkg::CMD_INSERT && req_position == '0)) begin
                  ctl.data_we   = 1'b1;
                  ctl.next_we   = 1'b1;
                  head_in       = new_slot;
                  if (is_empty) begin
                     tail_in = new_slot;
                  end
                  count_in      = count_inc;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = dlls_pkg::ST_INSERTED;
                  rsp_count_in  = dlls_pkg::COUNT_OUT_W'(count_inc);
               end else if (req_cmd == dlls_pkg::CMD_PUSH_BACK ||
                            req_position == count_pos) begin
                  // The new tail's own next link is never followed, so only the old tail
                  // gets its link written.
                  ctl.data_we   = 1'b1;
                  ctl.next_we   = !is_empty;
                  next_addr     = tail_ff;
                  next_wdata    = new_slot;
                  tail_in       = new_slot;
                  if (is_empty) begin
                     head_in = new_slot;
                  end
                  count_in      = count_inc;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = dlls_pkg::ST_INSERTED;
                  rsp_count_in  = dlls_pkg::COUNT_OUT_W'(count_inc);
               end else begin
                  ctl.rd_en = 1'b1;
                  cur_in    = head_ff;
                  rem_in    = pos_m1[CNT_W-1:0];
                  value_in  = req_item_value;
                  state_in  = S_WALK;
               end
            end
         end
         S_WALK: begin
            if (rem_ff == '0) begin
               // The node before the position is found; its successor becomes ours.
               ctl.data_we = 1'b1;
               ctl.next_we = 1'b1;
               data_wdata  = value_ff;
               next_wdata  = rd_next_ff;
               state_in    = S_STITCH;
            end else begin
               ctl.rd_en = 1'b1;
               rd_addr   = rd_next_ff;
               cur_in    = rd_next_ff;
               rem_in    = rem_ff - CNT_W'(1);
            end
         end
         S_STITCH: begin
            if (out_free) begin
               ctl.next_we   = 1'b1;
               next_addr     = cur_ff;
               next_wdata    = new_slot;
               count_in      = count_inc;
               rsp_valid_in  = 1'b1;
               rsp_status_in = dlls_pkg::ST_INSERTED;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
               rsp_count_in  = dlls_pkg::COUNT_OUT_W'(count_inc);
               state_in      = S_IDLE;
            end
         end
         S_READ: begin
            rd_addr = rd_next_ff;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = dlls_pkg::ST_ELEMENT;
               rsp_value_in  = rd_data_ff;
               rsp_last_in   = (rem_ff == '0);
               rsp_count_in  = dlls_pkg::COUNT_OUT_W'(count_ff);
               if (rem_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  ctl.rd_en = 1'b1;
                  rem_in    = rem_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("List count exceeds the pool size.");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && !full && (req_cmd == dlls_pkg::CMD_PUSH_FRONT ||
                           req_cmd == dlls_pkg::CMD_PUSH_BACK))
      |=> (count_ff == CNT_W'($past(count_ff) + CNT_W'(1))))
      else $error("A push into a pool with room did not add a node.");

   a_rem_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK || state_ff == S_READ) |-> (rem_ff < count_ff))
      else $error("Walk counter points beyond the list.");

   a_read_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !(ctl.data_we || ctl.next_we))
      else $error("Pool written during a read out.");

endmodule

@@ design/doubly_linked_list_store_top.sv @@
// A push is answered from idle. An insert at a middle position walks the pool, one
// memory read per cycle, then stitches the node in. A read out delivers one element a
// cycle while the consumer is ready; an empty list is answered from idle. Results
// leave through an output register; a stalled consumer holds the read out and the
// stitch. Synchronous reset empties the list; pool entries stay unwritten until used.
module doubly_linked_list_store_top #(
   parameter int CAPACITY = dlls_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // position[6:0], item_value[38:7], zero[39]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // element_value[31:0], element_count[38:32], zero[39]
   output logic [2:0]  rsp_tuser,   // status[2:0]
   output logic        rsp_tlast
);

   localparam int SLOT_W = $clog2(CAPACITY);

   dlls_pkg::mem_ctl_type               ctl;
   logic [SLOT_W-1:0]                   data_addr;
   logic signed [dlls_pkg::VALUE_W-1:0] data_wdata;
   logic [SLOT_W-1:0]                   next_addr;
   logic [SLOT_W-1:0]                   next_wdata;
   logic [SLOT_W-1:0]                   rd_addr;
   logic signed [dlls_pkg::VALUE_W-1:0] rd_data_ff;
   logic [SLOT_W-1:0]                   rd_next_ff;
   logic signed [dlls_pkg::VALUE_W-1:0] rsp_value;
   logic [dlls_pkg::COUNT_OUT_W-1:0]    rsp_count;

   dlls_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_cmd        (req_tuser),
      .req_position   (req_tdata[6:0]),
      .req_item_value (req_tdata[38:7]),
      .rsp_valid_ff   (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_status_ff  (rsp_tuser),
      .rsp_value_ff   (rsp_value),
      .rsp_last_ff    (rsp_tlast),
      .rsp_count_ff   (rsp_count),
      .ctl            (ctl),
      .data_addr      (data_addr),
      .data_wdata     (data_wdata),
      .next_addr      (next_addr),
      .next_wdata     (next_wdata),
      .rd_addr        (rd_addr),
      .rd_data_ff     (rd_data_ff),
      .rd_next_ff     (rd_next_ff)
   );

   dlls_node_mem #(
      .CAPACITY(CAPACITY)
   ) u_node_mem (
      .clock      (clock),
      .ctl        (ctl),
      .data_addr  (data_addr),
      .data_wdata (data_wdata),
      .next_addr  (next_addr),
      .next_wdata (next_wdata),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data_ff),
      .rd_next_ff (rd_next_ff)
   );

   assign rsp_tdata = {1'b0, rsp_count, rsp_value};

endmodule

@@ sim/tb_doubly_linked_list_store_top.sv @@
// Self-checking testbench for the doubly linked list store, with a shadow list and scoreboard.
module tb_doubly_linked_list_store_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP          = dlls_pkg::CAPACITY_DEF;
   localparam int N_RANDOM     = 500;
   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_CYCLES  = 400;
   localparam int MAX_POS      = 64;

   typedef struct {
      logic [dlls_pkg::STATUS_W-1:0]    status;
      logic [dlls_pkg::VALUE_W-1:0]     value;
      logic                             last;
      logic [dlls_pkg::COUNT_OUT_W-1:0] count;
   } list_rsp_type;

   class dll_shadow_type;
      logic [dlls_pkg::VALUE_W-1:0] node_data [CAP];
      int                           node_next [CAP];
      int                           node_prev [CAP];
      int                           head_slot;
      int                           tail_slot;
      int                           list_count;
      list_rsp_type                 expected_rsp[$];
      int                           mismatches;
      int                           checked;
      int                           status_seen [5];

      function new();
         head_slot  = 0;
         tail_slot  = 0;
         list_count = 0;
         mismatches = 0;
         checked    = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      function void add_rsp(logic [dlls_pkg::STATUS_W-1:0] st, logic [dlls_pkg::VALUE_W-1:0] v,
                            logic last);
         list_rsp_type r;
         r.status = st;
         r.value  = v;
         r.last   = last;
         r.count  = dlls_pkg::COUNT_OUT_W'(list_count);
         expected_rsp = {expected_rsp, r};
      endfunction

      function void note_request(dlls_pkg::cmd_type cmd, logic [dlls_pkg::POS_W-1:0] pos,
                                 logic [dlls_pkg::VALUE_W-1:0] v);
         int cur;
         int s;
         int after;
         if (cmd == dlls_pkg::CMD_READ_OUT) begin
            if (list_count == 0) begin
               add_rsp(dlls_pkg::ST_EMPTY, '0, 1'b1);
            end else begin
               cur = head_slot;
               for (int i = 0; i < list_count; i++) begin
                  add_rsp(dlls_pkg::ST_ELEMENT, node_data[cur], (i + 1 == list_count));
                  cur = node_next[cur];
               end
            end
            return;
         end
         if (cmd == dlls_pkg::CMD_INSERT && int'(pos) > list_count) begin
            add_rsp(dlls_pkg::ST_RANGE, '0, 1'b1);
            return;
         end
         if (list_count >= CAP) begin
            add_rsp(dlls_pkg::ST_FULL, '0, 1'b1);
            return;
         end
         s = list_count;
         node_data[s] = v;
         if (cmd == dlls_pkg::CMD_PUSH_FRONT || (cmd == dlls_pkg::CMD_INSERT && pos == 0)) begin
            node_prev[s] = 0;
            if (list_count == 0) begin
               node_next[s] = 0;
               tail_slot    = s;
            end else begin
               node_next[s]         = head_slot;
               node_prev[head_slot] = s;
            end
            head_slot = s;
         end else if (cmd == dlls_pkg::CMD_PUSH_BACK || int'(pos) == list_count) begin
            node_next[s] = 0;
            if (list_count == 0) begin
               node_prev[s] = 0;
               head_slot    = s;
            end else begin
               node_prev[s]         = tail_slot;
               node_next[tail_slot] = s;
            end
            tail_slot = s;
         end else begin
            cur = head_slot;
            for (int i = 0; i + 1 < int'(pos); i++) cur = node_next[cur];
            after = node_next[cur];
            node_prev[s]     = cur;
            node_next[s]     = after;
            node_prev[after] = s;
            node_next[cur]   = s;
         end
         list_count++;
         add_rsp(dlls_pkg::ST_INSERTED, '0, 1'b1);
      endfunction

      function void check_response(logic [dlls_pkg::STATUS_W-1:0] st,
                                   logic [dlls_pkg::VALUE_W-1:0] v, logic last,
                                   logic [dlls_pkg::COUNT_OUT_W-1:0] cnt);
         list_rsp_type e;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected transfer: status %0d value %h last %b count %0d",
                        $realtime, st, v, last, cnt);
            return;
         end
         e = expected_rsp.pop_front();
         checked++;
         if (e.status !== st || e.value !== v || e.last !== last || e.count !== cnt) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: mismatch: expected status %0d value %h last %b count %0d,",
                         " got status %0d value %h last %b count %0d"},
                        $realtime, e.status, e.value, e.last, e.count, st, v, last, cnt);
         end else if (st < 5) begin
            status_seen[st]++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   logic        hold_request = 1'b0;
   logic        hold_done    = 1'b0;
   int          hold_left    = 0;
   int unsigned rcv_cycle    = 0;

   dll_shadow_type shadow;
   int             items_sent = 0;
   int             reads_sent = 0;
   int             burst_left = 0;

   doubly_linked_list_store_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d transfers outstanding",
                     cycles, shadow.pending());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      rcv_cycle <= rcv_cycle + 1;
      if (hold_request && !hold_done) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (rcv_cycle[8:6])
            3'd0, 3'd1: rsp_tready <= 1'b1;
            3'd2:       rsp_tready <= rcv_cycle[0];
            3'd3:       rsp_tready <= ($urandom_range(0, 9) < 7);
            3'd4:       rsp_tready <= ($urandom_range(0, 9) < 3);
            3'd5:       rsp_tready <= (rcv_cycle[3:0] != 4'd0);
            default:    rsp_tready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         shadow.check_response(rsp_tuser, rsp_tdata[31:0], rsp_tlast, rsp_tdata[38:32]);
   end

   task automatic send_req(dlls_pkg::cmd_type cmd, logic [dlls_pkg::POS_W-1:0] pos,
                           logic [dlls_pkg::VALUE_W-1:0] v);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, v, pos};
      do @(posedge clock); while (!req_tready);
      shadow.note_request(cmd, pos, v);
      items_sent++;
      if (cmd == dlls_pkg::CMD_READ_OUT) reads_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = $urandom_range(0, 6);
         burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (shadow.pending() > 0) @(posedge clock);
      @(posedge clock);
   endtask

   initial begin
      int                           r;
      int                           cnt;
      dlls_pkg::cmd_type            cmd;
      logic [dlls_pkg::POS_W-1:0]   pos;
      shadow = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty list, out-of-range inserts, both ends, middle inserts, value extremes.
      send_req(dlls_pkg::CMD_READ_OUT,   7'd64, 32'hFFFF_FFFF);
      send_req(dlls_pkg::CMD_INSERT,     7'd1,  32'h1111_1111);
      send_req(dlls_pkg::CMD_INSERT,     7'd64, 32'h2222_2222);
      send_req(dlls_pkg::CMD_INSERT,     7'd0,  32'h8000_0000);
      send_req(dlls_pkg::CMD_PUSH_BACK,  7'd64, 32'h7FFF_FFFF);
      send_req(dlls_pkg::CMD_PUSH_FRONT, 7'd0,  32'hFFFF_FFFF);
      send_req(dlls_pkg::CMD_INSERT,     7'd1,  32'h0000_0000);
      send_req(dlls_pkg::CMD_INSERT,     7'd4,  32'h1234_5678);
      send_req(dlls_pkg::CMD_INSERT,     7'd2,  32'hA5A5_A5A5);
      send_req(dlls_pkg::CMD_INSERT,     7'd5,  32'h5A5A_5A5A);
      send_req(dlls_pkg::CMD_INSERT,     7'd8,  32'h3333_3333);
      send_req(dlls_pkg::CMD_INSERT,     7'd7,  32'h4444_4444);
      send_req(dlls_pkg::CMD_READ_OUT,   7'd0,  32'h0000_0000);
      send_req(dlls_pkg::CMD_PUSH_BACK,  7'd63, 32'h0000_0000);
      send_req(dlls_pkg::CMD_PUSH_FRONT, 7'd127 & 7'd64, 32'h8000_0001);
      send_req(dlls_pkg::CMD_READ_OUT,   7'd42, 32'h7FFF_FFFF);
      wait_drained();

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 120) hold_request <= 1'b1;
         if (i == 250) wait_drained();
         cnt = shadow.list_count;
         r   = $urandom_range(0, 99);
         pos = dlls_pkg::POS_W'($urandom_range(0, MAX_POS));
         if (r < 15) begin
            cmd = dlls_pkg::CMD_READ_OUT;
         end else if (r < 25) begin
            cmd = dlls_pkg::CMD_PUSH_FRONT;
         end else if (r < 35) begin
            cmd = dlls_pkg::CMD_PUSH_BACK;
         end else if (r < 80) begin
            cmd = dlls_pkg::CMD_INSERT;
            pos = dlls_pkg::POS_W'($urandom_range(0, cnt));
         end else begin
            cmd = dlls_pkg::CMD_INSERT;
            pos = dlls_pkg::POS_W'($urandom_range(cnt + 1, MAX_POS));
         end
         send_req(cmd, pos, $urandom());
      end

      req_tvalid <= 1'b0;
      while (shadow.pending() > 0) @(posedge clock);
      repeat (80) @(posedge clock);

      if (shadow.pending() > 0)
         $display("%0d expected transfers never arrived", shadow.pending());
      $display("Sent %0d requests (%0d read outs); checked %0d responses, %0d mismatches.",
               items_sent, reads_sent, shadow.checked, shadow.mismatches);
      $display("Responses by status: inserted %0d, range %0d, full %0d, element %0d, empty %0d.",
               shadow.status_seen[dlls_pkg::ST_INSERTED], shadow.status_seen[dlls_pkg::ST_RANGE],
               shadow.status_seen[dlls_pkg::ST_FULL], shadow.status_seen[dlls_pkg::ST_ELEMENT],
               shadow.status_seen[dlls_pkg::ST_EMPTY]);
      if (shadow.mismatches == 0 && shadow.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/dlls_pkg.sv
design/dlls_node_mem.sv
design/dlls_ctrl.sv
design/doubly_linked_list_store_top.sv
sim/tb_doubly_linked_list_store_top.sv
